[rtl/core/swer_pkg.sv]
// ----------------------------------------------------------------------------
// swer_pkg: shared types and constants of the sliding window event rate core
// Widths, microcode encoding and the control program of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package swer_pkg;

    localparam int RING_DEPTH = 256;
    localparam int TS_W       = 40;
    localparam int WIN_W      = 16;
    localparam int RATE_W     = 18;
    localparam int ADDR_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int LIVE_W     = $clog2(RING_DEPTH + 1);
    localparam int NUM_W      = LIVE_W + 10;
    localparam int CNT_W      = $clog2(NUM_W + 1);
    localparam int DEN_W      = WIN_W;
    localparam int CMP_W      = (NUM_W > RATE_W) ? NUM_W : RATE_W;

    localparam int STARTUP_MS = 250;
    localparam int MS_PER_S   = 1000;
    localparam int WIN_RESET  = 1000;
    localparam int RATE_MAX   = (2 ** RATE_W) - 1;

    typedef enum logic [2:0] {
        STEP_ACCEPT   = 3'd0,
        STEP_WRITE    = 3'd1,
        STEP_SEEK     = 3'd2,
        STEP_CHECK    = 3'd3,
        STEP_DIV_LOAD = 3'd4,
        STEP_DIV_RUN  = 3'd5,
        STEP_EMIT     = 3'd6,
        STEP_RETURN   = 3'd7
    } step_t;

    typedef enum logic [2:0] {
        OP_NONE     = 3'd0,
        OP_ACCEPT   = 3'd1,
        OP_WRITE    = 3'd2,
        OP_READ     = 3'd3,
        OP_CHECK    = 3'd4,
        OP_DIV_LOAD = 3'd5,
        OP_DIV_STEP = 3'd6,
        OP_EMIT     = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT      = 3'd0,
        C_ALWAYS    = 3'd1,
        C_NO_IN     = 3'd2,
        C_WALK_DONE = 3'd3,
        C_OLDER     = 3'd4,
        C_DIV_BUSY  = 3'd5,
        C_OUT_FULL  = 3'd6
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } uword_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

    // Control program. A word jumps to its target when its condition holds
    // and otherwise falls through to the next step.
    function automatic uword_t ucode_rom(input step_t s);
        uword_t w;
        case (s)
            STEP_ACCEPT:   w = '{op: OP_ACCEPT,   cond: C_NO_IN,     target: STEP_ACCEPT};
            STEP_WRITE:    w = '{op: OP_WRITE,    cond: C_NEXT,      target: STEP_SEEK};
            STEP_SEEK:     w = '{op: OP_READ,     cond: C_WALK_DONE, target: STEP_DIV_LOAD};
            STEP_CHECK:    w = '{op: OP_CHECK,    cond: C_OLDER,     target: STEP_SEEK};
            STEP_DIV_LOAD: w = '{op: OP_DIV_LOAD, cond: C_NEXT,      target: STEP_DIV_RUN};
            STEP_DIV_RUN:  w = '{op: OP_DIV_STEP, cond: C_DIV_BUSY,  target: STEP_DIV_RUN};
            STEP_EMIT:     w = '{op: OP_EMIT,     cond: C_OUT_FULL,  target: STEP_EMIT};
            STEP_RETURN:   w = '{op: OP_NONE,     cond: C_ALWAYS,    target: STEP_ACCEPT};
            default:       w = '{op: OP_NONE,     cond: C_ALWAYS,    target: STEP_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/core/swer_div.sv]
// ----------------------------------------------------------------------------
// swer_div: restoring divider, one quotient bit per cycle while stepped
// Loads numerator and divisor, then develops the quotient MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module swer_div (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire swer_pkg::div_ctrl_t     ctrl,
    input  wire [swer_pkg::NUM_W-1:0]    numer,
    input  wire [swer_pkg::DEN_W-1:0]    denom,
    output logic [swer_pkg::NUM_W-1:0]   quot,
    output logic                         busy
);
    import swer_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;

    always_comb
    begin
        rem_sh    = {rem_reg, quot_reg[NUM_W-1]};
        diff      = rem_sh - {1'b0, den_reg};
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (ctrl.load)
        begin
            cnt_next  = CNT_W'(NUM_W);
            quot_next = numer;
            rem_next  = '0;
            den_next  = denom;
        end
        else if (ctrl.step && (cnt_reg != '0))
        begin
            cnt_next = cnt_reg - 1'b1;
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next  = diff[DEN_W-1:0];
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[DEN_W-1:0];
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign quot = quot_reg;
    assign busy = (cnt_reg != '0);

endmodule

`default_nettype wire

[rtl/core/sliding_window_event_rate_core.sv]
// ----------------------------------------------------------------------------
// sliding_window_event_rate_core: events-per-second meter over a time window
// Stores event timestamps in a ring, drops those that fell out of the window
// and divides the live count by the window or the startup time.
// ----------------------------------------------------------------------------
// Each input beat is one event with a millisecond timestamp and yields exactly
// one output beat with the event rate in events per second. The block works on
// one event at a time under a small microcoded sequencer. Each event is
// accepted, written to the ring, checked for old entries, divided and then
// emitted. No entry is checked while the event's time is still below the
// window length; otherwise the drop walk checks the oldest entries and drops
// each one that fell out of the window. An event may also wait at the emit
// step for the output register to drain. The divider develops one quotient
// bit per cycle; the drop walk reads the timestamp ring through its single
// read port, with a read step and a check step per entry. The output register
// holds a finished result while the next event is already accepted. The
// window length is written on the configuration channel (cfg_ready is always
// high) and must only change while the block is idle; a window of zero acts
// as one millisecond. The timestamp ring has no reset; only entries that
// have been written are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_event_rate_core (
    input  wire                           clk,
    input  wire                           rst_n,
    // Configuration channel.
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire [swer_pkg::WIN_W-1:0]     window_ms,
    // Event input channel.
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire [swer_pkg::TS_W-1:0]      timestamp_ms,
    // Rate output channel.
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic [swer_pkg::RATE_W-1:0]   rate_per_s
);
    import swer_pkg::*;

    // Sequencer state.
    step_t  step_reg, step_next;
    uword_t uword;
    logic   cond_true;

    // Datapath registers.
    logic [WIN_W-1:0]  window_reg, window_next;
    logic [TS_W-1:0]   now_reg, now_next;
    logic [TS_W-1:0]   first_time_reg, first_time_next;
    logic              started_reg, started_next;
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [LIVE_W-1:0] live_reg, live_next;
    logic [TS_W-1:0]   cutoff_reg, cutoff_next;
    logic              walk_en_reg, walk_en_next;
    logic              out_valid_reg, out_valid_next;
    logic [RATE_W-1:0] rate_reg, rate_next;
    logic [TS_W-1:0]   rd_data_reg;

    // The ring of recent timestamps.
    logic [TS_W-1:0] ring_mem [RING_DEPTH];

    // Decoded control.
    logic do_accept, do_write, do_read, do_check, do_emit;
    div_ctrl_t div_ctrl;

    // Combinational helpers.
    logic [WIN_W-1:0]  win_eff;
    logic [ADDR_W-1:0] oldest_addr;
    logic              older;
    logic              out_full;
    logic [TS_W:0]     elapsed_full;
    logic              elapsed_neg;
    logic              in_startup;
    logic [DEN_W-1:0]  divisor;
    logic [NUM_W-1:0]  numer;
    logic [NUM_W-1:0]  quot;
    logic              div_busy;

    assign win_eff  = (window_reg == '0) ? WIN_W'(1) : window_reg;
    assign older    = (rd_data_reg < cutoff_reg);
    assign out_full = out_valid_reg && !out_ready;

    // The oldest live entry sits live_count slots behind the write pointer.
    always_comb
    begin
        if (LIVE_W'(wp_reg) >= live_reg)
        begin
            oldest_addr = ADDR_W'(LIVE_W'(wp_reg) - live_reg);
        end
        else
        begin
            oldest_addr = ADDR_W'(LIVE_W'(wp_reg) + LIVE_W'(RING_DEPTH) - live_reg);
        end
    end

    // Divisor: elapsed time during startup (at least one), the window after.
    // A timestamp before the first one counts as zero elapsed time.
    always_comb
    begin
        elapsed_full = {1'b0, now_reg} - {1'b0, first_time_reg};
        elapsed_neg  = elapsed_full[TS_W];
        in_startup   = elapsed_neg || (elapsed_full[TS_W-1:0] < TS_W'(STARTUP_MS));
        if (!in_startup)
        begin
            divisor = win_eff;
        end
        else if (elapsed_neg || (elapsed_full[TS_W-1:0] == '0))
        begin
            divisor = DEN_W'(1);
        end
        else
        begin
            divisor = DEN_W'(elapsed_full[TS_W-1:0]);
        end
        numer = NUM_W'(live_reg) * NUM_W'(MS_PER_S);
    end

    swer_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .numer (numer),
        .denom (divisor),
        .quot  (quot),
        .busy  (div_busy)
    );

    // Next step: follow the jump when the word's condition holds.
    always_comb
    begin
        uword = ucode_rom(step_reg);
        case (uword.cond)
            C_NEXT:      cond_true = 1'b0;
            C_ALWAYS:    cond_true = 1'b1;
            C_NO_IN:     cond_true = !in_valid;
            C_WALK_DONE: cond_true = !walk_en_reg || (live_reg == '0);
            C_OLDER:     cond_true = older;
            C_DIV_BUSY:  cond_true = div_busy;
            C_OUT_FULL:  cond_true = out_full;
            default:     cond_true = 1'b1;
        endcase
        if (cond_true)
        begin
            step_next = uword.target;
        end
        else
        begin
            step_next = step_t'(step_reg + 3'd1);
        end
    end

    // Control word decode.
    always_comb
    begin
        do_accept     = 1'b0;
        do_write      = 1'b0;
        do_read       = 1'b0;
        do_check      = 1'b0;
        do_emit       = 1'b0;
        div_ctrl.load = 1'b0;
        div_ctrl.step = 1'b0;
        case (uword.op)
            OP_NONE:     ;
            OP_ACCEPT:   do_accept = in_valid;
            OP_WRITE:    do_write = 1'b1;
            OP_READ:     do_read = 1'b1;
            OP_CHECK:    do_check = 1'b1;
            OP_DIV_LOAD: div_ctrl.load = 1'b1;
            OP_DIV_STEP: div_ctrl.step = 1'b1;
            OP_EMIT:     do_emit = !out_full;
            default:     ;
        endcase
    end

    assign in_ready  = (uword.op == OP_ACCEPT);
    assign cfg_ready = 1'b1;

    // Datapath next values.
    always_comb
    begin
        window_next     = window_reg;
        now_next        = now_reg;
        first_time_next = first_time_reg;
        started_next    = started_reg;
        wp_next         = wp_reg;
        live_next       = live_reg;
        cutoff_next     = cutoff_reg;
        walk_en_next    = walk_en_reg;
        out_valid_next  = out_valid_reg;
        rate_next       = rate_reg;

        if (cfg_valid)
        begin
            window_next = window_ms;
        end
        if (do_accept)
        begin
            now_next = timestamp_ms;
        end
        if (do_write)
        begin
            if (!started_reg)
            begin
                first_time_next = now_reg;
                started_next    = 1'b1;
            end
            wp_next = (wp_reg == ADDR_W'(RING_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (live_reg < LIVE_W'(RING_DEPTH))
            begin
                live_next = live_reg + 1'b1;
            end
            walk_en_next = (now_reg >= TS_W'(win_eff));
            cutoff_next  = now_reg - TS_W'(win_eff);
        end
        if (do_check && older)
        begin
            live_next = live_reg - 1'b1;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (do_emit)
        begin
            out_valid_next = 1'b1;
            if (CMP_W'(quot) > CMP_W'(RATE_MAX))
            begin
                rate_next = RATE_W'(RATE_MAX);
            end
            else
            begin
                rate_next = RATE_W'(quot);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= STEP_ACCEPT;
            window_reg     <= WIN_W'(WIN_RESET);
            first_time_reg <= '0;
            started_reg    <= 1'b0;
            wp_reg         <= '0;
            live_reg       <= '0;
            walk_en_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            step_reg       <= step_next;
            window_reg     <= window_next;
            first_time_reg <= first_time_next;
            started_reg    <= started_next;
            wp_reg         <= wp_next;
            live_reg       <= live_next;
            walk_en_reg    <= walk_en_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg    <= now_next;
        cutoff_reg <= cutoff_next;
        rate_reg   <= rate_next;
    end

    // Timestamp ring: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            ring_mem[wp_reg] <= now_reg;
        end
        if (do_read)
        begin
            rd_data_reg <= ring_mem[oldest_addr];
        end
    end

    assign out_valid  = out_valid_reg;
    assign rate_per_s = rate_reg;

`ifndef SYNTHESIS
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= LIVE_W'(RING_DEPTH))
        else $error("live count exceeds ring depth");

    a_accept_then_write: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (step_reg == STEP_WRITE))
        else $error("accepted beat not followed by ring write");

    a_check_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_CHECK) |-> (live_reg != '0))
        else $error("drop check with no live entry");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(step_reg) == STEP_EMIT))
        else $error("output beat raised outside the emit step");
`endif

endmodule

`default_nettype wire
